@@ design/ebml_element_header_parser_top_defines.svh @@
// Assertion helpers for the EBML element header parser.
`ifndef EBML_ELEMENT_HEADER_PARSER_TOP_DEFINES_SVH
`define EBML_ELEMENT_HEADER_PARSER_TOP_DEFINES_SVH

// A property that is checked only while reset is low.
`define EHP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ebml header parser check failed");

// A property that is also checked during and right after reset.
`define EHP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ebml header parser check failed");

`endif

@@ design/ehp_pkg.sv @@
`default_nettype none

package ehp_pkg;

   typedef logic [1:0] phase_type;

   // Parser phases.
   localparam phase_type PH_ID_FIRST   = 2'd0;
   localparam phase_type PH_ID_REST    = 2'd1;
   localparam phase_type PH_SIZE_FIRST = 2'd2;
   localparam phase_type PH_SIZE_REST  = 2'd3;

   localparam logic [7:0] LEAD_MARK = 8'h80;

   localparam int NUM_MASTER_IDS = 4;

   // Configuration register indexes.
   localparam logic [7:0] CSR_MASTER_ID_A = 8'd0;
   localparam logic [7:0] CSR_MASTER_ID_B = 8'd1;
   localparam logic [7:0] CSR_MASTER_ID_C = 8'd2;
   localparam logic [7:0] CSR_MASTER_ID_D = 8'd3;

   // Width of a variable-length integer, taken from its leading byte.
   // A zero byte never reaches this function in a meaningful way.
   function automatic logic [3:0] lead_width(input logic [7:0] lead);
      logic [3:0] width;
      priority casez (lead)
         8'b1???????: width = 4'd1;
         8'b01??????: width = 4'd2;
         8'b001?????: width = 4'd3;
         8'b0001????: width = 4'd4;
         8'b00001???: width = 4'd5;
         8'b000001??: width = 4'd6;
         8'b0000001?: width = 4'd7;
         default:     width = 4'd8;
      endcase
      return width;
   endfunction

   // Marker bit of a leading byte whose integer is the given width.
   function automatic logic [7:0] lead_mark(input logic [3:0] width);
      return LEAD_MARK >> (width - 4'd1);
   endfunction

endpackage

`default_nettype wire

@@ design/ebml_element_header_parser_top.sv @@
`default_nettype none

// Channel     Direction  Handshake              Payload
// req_*       in         req_valid / req_stall  one stream byte
// rsp_*       out        rsp_valid / rsp_stall  one decoded element header
// csr_*       in         csr_write_enable       master ID registers 0 to 3
//
// One byte is taken in every cycle while req_stall is low; the next state and
// any header result are computed in the cycle of the transfer and land in the
// state and result registers; rsp_* shows a header the cycle after its last size byte.
// Reset is synchronous and active high and returns the parser to the start of
// an ID with the master registers cleared. req_stall is raised only while a
// result waits in the output register and the consumer stalls it.
module ebml_element_header_parser_top
   import ehp_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_element_id,
   output logic [3:0]       rsp_id_width,
   output logic [55:0]      rsp_payload_size,
   output logic [3:0]       rsp_size_width,
   output logic             rsp_is_master,
   output logic [31:0]      rsp_header_offset,

   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   // Configuration registers. A zero entry never matches.
   logic [31:0] master_id_ff [NUM_MASTER_IDS];

   // Parser state.
   phase_type                phase_ff, phase_in;
   logic [3:0]               bytes_left_ff, bytes_left_in;
   logic [63:0]              accum_ff, accum_in;
   logic [63:0]              held_id_ff, held_id_in;
   logic [3:0]               held_id_width_ff, held_id_width_in;
   logic [3:0]               held_size_width_ff, held_size_width_in;
   logic [55:0]              payload_left_ff, payload_left_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] header_start_ff, header_start_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_id_ff;
   logic [3:0]  rsp_id_width_ff;
   logic [55:0] rsp_size_ff;
   logic [3:0]  rsp_size_width_ff;
   logic        rsp_master_ff;
   logic [31:0] rsp_offset_ff;

   logic        accept;
   logic        finish;
   logic [55:0] finish_size;
   logic [3:0]  lead_w;
   logic [7:0]  lead_m;
   logic        id_is_master;
   logic [63:0] start_wide;

   // The input side only waits when a finished header still sits in the
   // result register and is not being taken this cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign lead_w = lead_width(req_data_byte);
   assign lead_m = lead_mark(lead_w);

   // The held ID is complete before any size byte arrives, so the match can
   // be taken straight from its register.
   always_comb begin
      id_is_master = 1'b0;
      for (int i = 0; i < NUM_MASTER_IDS; i++) begin
         if (master_id_ff[i] != 32'd0 && held_id_ff == {32'd0, master_id_ff[i]}) begin
            id_is_master = 1'b1;
         end
      end
   end

   // Next parser state for the byte of this transfer.
   always_comb begin
      phase_in           = phase_ff;
      bytes_left_in      = bytes_left_ff;
      accum_in           = accum_ff;
      held_id_in         = held_id_ff;
      held_id_width_in   = held_id_width_ff;
      held_size_width_in = held_size_width_ff;
      payload_left_in    = payload_left_ff;
      position_in        = position_ff + POSITION_BITS'(1);
      header_start_in    = header_start_ff;
      finish             = 1'b0;
      finish_size        = 56'd0;

      unique case (phase_ff)
         PH_ID_FIRST: begin
            if (payload_left_ff != 56'd0) begin
               // Skipping the data of an element that is not a container.
               payload_left_in = payload_left_ff - 56'd1;
            end else if (req_data_byte != 8'd0) begin
               header_start_in  = position_ff;
               held_id_width_in = lead_w;
               accum_in         = {56'd0, req_data_byte};
               bytes_left_in    = lead_w - 4'd1;
               if (lead_w == 4'd1) begin
                  held_id_in = {56'd0, req_data_byte};
                  phase_in   = PH_SIZE_FIRST;
               end else begin
                  phase_in = PH_ID_REST;
               end
            end
         end
         PH_ID_REST: begin
            accum_in      = {accum_ff[55:0], req_data_byte};
            bytes_left_in = bytes_left_ff - 4'd1;
            if (bytes_left_in == 4'd0) begin
               held_id_in = {accum_ff[55:0], req_data_byte};
               phase_in   = PH_SIZE_FIRST;
            end
         end
         PH_SIZE_FIRST: begin
            if (req_data_byte != 8'd0) begin
               held_size_width_in = lead_w;
               accum_in           = {56'd0, req_data_byte ^ lead_m};
               bytes_left_in      = lead_w - 4'd1;
               if (lead_w == 4'd1) begin
                  finish = 1'b1;
               end else begin
                  phase_in = PH_SIZE_REST;
               end
            end
         end
         PH_SIZE_REST: begin
            accum_in      = {8'd0, accum_ff[47:0], req_data_byte};
            bytes_left_in = bytes_left_ff - 4'd1;
            if (bytes_left_in == 4'd0) begin
               finish = 1'b1;
            end
         end
         default: begin
            phase_in = PH_ID_FIRST;
         end
      endcase

      // At the end of a header a container is entered directly, anything
      // else has its data skipped. The size is kept for the result before
      // the accumulator is cleared.
      if (finish) begin
         finish_size     = accum_in[55:0];
         payload_left_in = id_is_master ? 56'd0 : finish_size;
         phase_in        = PH_ID_FIRST;
         bytes_left_in   = 4'd0;
         accum_in        = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_ID_FIRST;
         bytes_left_ff      <= 4'd0;
         accum_ff           <= 64'd0;
         held_id_ff         <= 64'd0;
         held_id_width_ff   <= 4'd1;
         held_size_width_ff <= 4'd1;
         payload_left_ff    <= 56'd0;
         position_ff        <= '0;
         header_start_ff    <= '0;
      end else if (accept) begin
         phase_ff           <= phase_in;
         bytes_left_ff      <= bytes_left_in;
         accum_ff           <= accum_in;
         held_id_ff         <= held_id_in;
         held_id_width_ff   <= held_id_width_in;
         held_size_width_ff <= held_size_width_in;
         payload_left_ff    <= payload_left_in;
         position_ff        <= position_in;
         header_start_ff    <= header_start_in;
      end
   end

   // Configuration writes; indexes past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MASTER_IDS; i++) begin
            master_id_ff[i] <= 32'd0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MASTER_ID_A: master_id_ff[0] <= csr_write_data;
            CSR_MASTER_ID_B: master_id_ff[1] <= csr_write_data;
            CSR_MASTER_ID_C: master_id_ff[2] <= csr_write_data;
            CSR_MASTER_ID_D: master_id_ff[3] <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // The offset is reported as the low 32 bits of the start position,
   // zero-extended when the position counter is narrower.
   assign start_wide = 64'(header_start_ff);

   always_comb begin
      if (accept && finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new header is only loaded when the register is empty or drains now.
   always_ff @(posedge clock) begin
      if (accept && finish) begin
         rsp_id_ff         <= held_id_ff;
         rsp_id_width_ff   <= held_id_width_ff;
         rsp_size_ff       <= finish_size;
         rsp_size_width_ff <= held_size_width_in;
         rsp_master_ff     <= id_is_master;
         rsp_offset_ff     <= start_wide[31:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_id    = rsp_id_ff;
   assign rsp_id_width      = rsp_id_width_ff;
   assign rsp_payload_size  = rsp_size_ff;
   assign rsp_size_width    = rsp_size_width_ff;
   assign rsp_is_master     = rsp_master_ff;
   assign rsp_header_offset = rsp_offset_ff;

endmodule

`default_nettype wire

@@ design/ehp_checker.sv @@
`default_nettype none

`include "ebml_element_header_parser_top_defines.svh"

module ehp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_element_id,
   input wire logic [3:0]  rsp_id_width,
   input wire logic [3:0]  rsp_size_width
);

   // A stalled result stays put until it is taken.
   `EHP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element_id))

   // The input side only waits behind a result that is itself stalled.
   `EHP_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   // Both integer widths of a reported header lie between one and eight bytes.
   `EHP_ASSERT(a_width_range, clock, reset, rsp_valid |-> rsp_id_width >= 4'd1 && rsp_id_width <= 4'd8 && rsp_size_width >= 4'd1 && rsp_size_width <= 4'd8)

   // No result is offered in the cycle after reset, nor any input refused.
   `EHP_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid && !req_stall)

endmodule

bind ebml_element_header_parser_top ehp_checker u_ehp_checker (.*);

`default_nettype wire
